FILE: hdl/acn_pkg.sv
package acn_pkg;

    // Input kinds
    localparam logic [2:0] KIND_FIT_NORM  = 3'd0;
    localparam logic [2:0] KIND_NORM      = 3'd1;
    localparam logic [2:0] KIND_FIT       = 3'd2;
    localparam logic [2:0] KIND_CLEAR     = 3'd3;
    localparam logic [2:0] KIND_CLEAR_ALL = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_ACTIVE = 2'd0;
    localparam logic [1:0] CFG_RATE   = 2'd1;
    localparam logic [1:0] CFG_GAIN   = 2'd2;

    // Reset values and limits
    localparam logic [4:0]  ACTIVE_RESET = 5'd16;
    localparam logic [15:0] RATE_RESET   = 16'd655;
    localparam logic [15:0] GAIN_RESET   = 16'd256;
    localparam logic [15:0] RATE_MIN     = 16'd66;
    localparam logic [15:0] RATE_MAX     = 16'd32768;
    localparam logic [31:0] VAR_ONE      = 32'd65536;
    localparam logic [31:0] VAR_MIN      = 32'd7;

    // Start values of the square root and divide loop counters
    localparam logic [5:0] SQRT_LAST = 6'd24;
    localparam logic [5:0] DIV_LAST  = 6'd48;

    typedef struct packed {
        logic [2:0]         kind;
        logic [7:0]         channel;
        logic signed [31:0] sample;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] normalized;
        logic               accepted;
        logic               forced_zero;
    } t_out_word;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_STEP, OP_MEAN, OP_DIFF, OP_SQ_LO, OP_SQ_HI, OP_D2,
        OP_V0, OP_V1, OP_V2, OP_VSAT, OP_G, OP_R0, OP_R1, OP_RATE,
        OP_SQ_INIT, OP_SQRT, OP_DIV_INIT, OP_DIV, OP_CLEAR, OP_SWEEP, OP_EMIT
    } t_op;

    typedef enum logic [1:0] {
        RES_ZERO, RES_ECHO, RES_FORCED, RES_QUOT
    } t_res;

    typedef struct packed {
        t_op  op;
        t_res res;
    } t_cmd;

    typedef struct packed {
        logic [2:0] kind;
        logic       ok;
        logic       forced;
        logic       cnt_last;
        logic       sweep_done;
        logic       out_free;
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_STEP, S_MEAN, S_DIFF, S_SQ_LO, S_SQ_HI, S_D2,
        S_V0, S_V1, S_V2, S_VSAT, S_G, S_R0, S_R1, S_RATE, S_CHECK,
        S_SQ_INIT, S_SQRT, S_DIV_INIT, S_DIV, S_CLEAR, S_SWEEP, S_EMIT
    } t_state;

endpackage

FILE: hdl/acn_ctrl.sv
module acn_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  acn_pkg::t_status i_status,
    output acn_pkg::t_cmd    o_cmd,
    output logic             o_busy
);

    acn_pkg::t_state r_state, n_state;
    acn_pkg::t_res   r_res, n_res;

    // Hold state and pending result selection
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= acn_pkg::S_IDLE;
            r_res   <= acn_pkg::RES_ZERO;
        end else begin
            r_state <= n_state;
            r_res   <= n_res;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        n_res   = r_res;
        case (r_state)
            acn_pkg::S_IDLE: begin
                if (i_valid) n_state = acn_pkg::S_DISPATCH;
            end
            acn_pkg::S_DISPATCH: begin
                n_state = acn_pkg::S_EMIT;
                n_res   = acn_pkg::RES_ZERO;
                case (i_status.kind)
                    acn_pkg::KIND_FIT_NORM: begin
                        if (i_status.ok) n_state = acn_pkg::S_STEP;
                        else n_res = acn_pkg::RES_ECHO;
                    end
                    acn_pkg::KIND_NORM: begin
                        if (i_status.ok) n_state = acn_pkg::S_CHECK;
                        else n_res = acn_pkg::RES_ECHO;
                    end
                    acn_pkg::KIND_FIT: begin
                        if (i_status.ok) n_state = acn_pkg::S_STEP;
                    end
                    acn_pkg::KIND_CLEAR: begin
                        if (i_status.ok) n_state = acn_pkg::S_CLEAR;
                    end
                    acn_pkg::KIND_CLEAR_ALL: n_state = acn_pkg::S_SWEEP;
                    default: n_state = acn_pkg::S_EMIT;
                endcase
            end
            acn_pkg::S_STEP:  n_state = acn_pkg::S_MEAN;
            acn_pkg::S_MEAN:  n_state = acn_pkg::S_DIFF;
            acn_pkg::S_DIFF:  n_state = acn_pkg::S_SQ_LO;
            acn_pkg::S_SQ_LO: n_state = acn_pkg::S_SQ_HI;
            acn_pkg::S_SQ_HI: n_state = acn_pkg::S_D2;
            acn_pkg::S_D2:    n_state = acn_pkg::S_V0;
            acn_pkg::S_V0:    n_state = acn_pkg::S_V1;
            acn_pkg::S_V1:    n_state = acn_pkg::S_V2;
            acn_pkg::S_V2:    n_state = acn_pkg::S_VSAT;
            acn_pkg::S_VSAT:  n_state = acn_pkg::S_G;
            acn_pkg::S_G:     n_state = acn_pkg::S_R0;
            acn_pkg::S_R0:    n_state = acn_pkg::S_R1;
            acn_pkg::S_R1:    n_state = acn_pkg::S_RATE;
            acn_pkg::S_RATE: begin
                if (i_status.kind == acn_pkg::KIND_FIT_NORM) begin
                    n_state = acn_pkg::S_CHECK;
                end else begin
                    n_state = acn_pkg::S_EMIT;
                    n_res   = acn_pkg::RES_ZERO;
                end
            end
            acn_pkg::S_CHECK: begin
                if (i_status.forced) begin
                    n_state = acn_pkg::S_EMIT;
                    n_res   = acn_pkg::RES_FORCED;
                end else begin
                    n_state = acn_pkg::S_SQ_INIT;
                end
            end
            acn_pkg::S_SQ_INIT: n_state = acn_pkg::S_SQRT;
            acn_pkg::S_SQRT: begin
                if (i_status.cnt_last) n_state = acn_pkg::S_DIV_INIT;
            end
            acn_pkg::S_DIV_INIT: n_state = acn_pkg::S_DIV;
            acn_pkg::S_DIV: begin
                if (i_status.cnt_last) begin
                    n_state = acn_pkg::S_EMIT;
                    n_res   = acn_pkg::RES_QUOT;
                end
            end
            acn_pkg::S_CLEAR: begin
                n_state = acn_pkg::S_EMIT;
                n_res   = acn_pkg::RES_ZERO;
            end
            acn_pkg::S_SWEEP: begin
                if (i_status.sweep_done) begin
                    n_state = acn_pkg::S_EMIT;
                    n_res   = acn_pkg::RES_ZERO;
                end
            end
            acn_pkg::S_EMIT: begin
                if (i_status.out_free) n_state = acn_pkg::S_IDLE;
            end
            default: n_state = acn_pkg::S_IDLE;
        endcase
    end

    // Command outputs
    always_comb begin
        o_cmd.op  = acn_pkg::OP_NONE;
        o_cmd.res = r_res;
        case (r_state)
            acn_pkg::S_IDLE:     if (i_valid) o_cmd.op = acn_pkg::OP_LOAD;
            acn_pkg::S_STEP:     o_cmd.op = acn_pkg::OP_STEP;
            acn_pkg::S_MEAN:     o_cmd.op = acn_pkg::OP_MEAN;
            acn_pkg::S_DIFF:     o_cmd.op = acn_pkg::OP_DIFF;
            acn_pkg::S_SQ_LO:    o_cmd.op = acn_pkg::OP_SQ_LO;
            acn_pkg::S_SQ_HI:    o_cmd.op = acn_pkg::OP_SQ_HI;
            acn_pkg::S_D2:       o_cmd.op = acn_pkg::OP_D2;
            acn_pkg::S_V0:       o_cmd.op = acn_pkg::OP_V0;
            acn_pkg::S_V1:       o_cmd.op = acn_pkg::OP_V1;
            acn_pkg::S_V2:       o_cmd.op = acn_pkg::OP_V2;
            acn_pkg::S_VSAT:     o_cmd.op = acn_pkg::OP_VSAT;
            acn_pkg::S_G:        o_cmd.op = acn_pkg::OP_G;
            acn_pkg::S_R0:       o_cmd.op = acn_pkg::OP_R0;
            acn_pkg::S_R1:       o_cmd.op = acn_pkg::OP_R1;
            acn_pkg::S_RATE:     o_cmd.op = acn_pkg::OP_RATE;
            acn_pkg::S_SQ_INIT:  o_cmd.op = acn_pkg::OP_SQ_INIT;
            acn_pkg::S_SQRT:     o_cmd.op = acn_pkg::OP_SQRT;
            acn_pkg::S_DIV_INIT: o_cmd.op = acn_pkg::OP_DIV_INIT;
            acn_pkg::S_DIV:      o_cmd.op = acn_pkg::OP_DIV;
            acn_pkg::S_CLEAR:    o_cmd.op = acn_pkg::OP_CLEAR;
            acn_pkg::S_SWEEP:    if (!i_status.sweep_done) o_cmd.op = acn_pkg::OP_SWEEP;
            acn_pkg::S_EMIT:     if (i_status.out_free) o_cmd.op = acn_pkg::OP_EMIT;
            default:             o_cmd.op = acn_pkg::OP_NONE;
        endcase
    end

    assign o_busy = (r_state != acn_pkg::S_IDLE);

endmodule

FILE: hdl/acn_datapath.sv
module acn_datapath #(
    parameter int CHANNELS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  acn_pkg::t_cmd     i_cmd,
    input  acn_pkg::t_in_word i_data,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [15:0]       i_cfg_wdata,
    input  logic              i_stall,
    output acn_pkg::t_status  o_status,
    output logic              o_valid,
    output acn_pkg::t_out_word o_data
);

    localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Configuration
    logic [4:0]  r_active;
    logic [15:0] r_irate;
    logic [15:0] r_gain;

    // Channel state
    logic signed [31:0] r_mean_st [CHANNELS];
    logic [31:0]        r_var_st  [CHANNELS];
    logic [15:0]        r_rate_st [CHANNELS];
    logic               r_seen_st [CHANNELS];

    // Working registers
    logic [2:0]         r_kind;
    logic [7:0]         r_ch;
    logic signed [31:0] r_x;
    logic               r_ok;
    logic signed [31:0] r_m;
    logic [31:0]        r_v;
    logic [15:0]        r_lr;
    logic               r_seen;
    logic [65:0]        r_acc;
    logic [32:0]        r_ad;
    logic [48:0]        r_d2;
    logic [31:0]        r_vn;
    logic [48:0]        r_g;
    logic [48:0]        r_sx;
    logic [48:0]        r_sr;
    logic [48:0]        r_sb;
    logic [48:0]        r_dn;
    logic [24:0]        r_rem;
    logic [24:0]        r_s;
    logic               r_neg;
    logic [5:0]         r_cnt;
    logic [8:0]         r_sw;
    logic               r_ovalid;
    acn_pkg::t_out_word r_out;

    // Combinational helpers
    logic [8:0]         lim9;
    logic               in_ok;
    logic               in_acc;
    logic [IW-1:0]      in_idx;
    logic [IW-1:0]      ch_idx;
    logic [IW-1:0]      sw_idx;
    logic signed [32:0] d0;
    logic [32:0]        mag0;
    logic [32:0]        mul_a;
    logic [16:0]        mul_b;
    logic [49:0]        prod;
    logic [65:0]        prod_ext;
    logic [65:0]        acc_rnd16;
    logic [65:0]        acc_rnd24;
    logic [32:0]        step;
    logic signed [33:0] mn34;
    logic signed [31:0] mn_sat;
    logic [33:0]        nr_sum;
    logic [33:0]        nr_raw;
    logic [15:0]        nr;
    logic [48:0]        sq_t;
    logic [25:0]        dv_t;
    logic [25:0]        dv_s;
    logic [32:0]        qc;
    logic signed [31:0] quot;
    logic               out_free;

    assign lim9   = (9'(r_active) < 9'(CHANNELS)) ? 9'(r_active) : 9'(CHANNELS);
    assign in_ok  = 9'(i_data.channel) < lim9;
    assign in_acc = (i_data.kind == acn_pkg::KIND_CLEAR_ALL) ? 1'b1 :
                    (i_data.kind <= acn_pkg::KIND_CLEAR) ? in_ok : 1'b0;
    assign in_idx = i_data.channel[IW-1:0];
    assign ch_idx = r_ch[IW-1:0];
    assign sw_idx = r_sw[IW-1:0];

    // Difference of sample and current mean, and its magnitude
    assign d0   = 33'(r_x) - 33'(r_m);
    assign mag0 = d0[32] ? 33'(-d0) : 33'(d0);

    // Shared multiplier operand selection
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            acn_pkg::OP_STEP:  begin mul_a = mag0; mul_b = {1'b0, r_lr}; end
            acn_pkg::OP_SQ_LO: begin mul_a = r_ad; mul_b = {1'b0, r_ad[15:0]}; end
            acn_pkg::OP_SQ_HI: begin mul_a = r_ad; mul_b = r_ad[32:16]; end
            acn_pkg::OP_V0:    begin mul_a = {1'b0, r_v}; mul_b = 17'h10000 - 17'(r_lr); end
            acn_pkg::OP_V1:    begin mul_a = {17'b0, r_d2[15:0]}; mul_b = {1'b0, r_lr}; end
            acn_pkg::OP_V2:    begin mul_a = r_d2[48:16]; mul_b = {1'b0, r_lr}; end
            acn_pkg::OP_G:     begin mul_a = r_ad; mul_b = {1'b0, r_gain}; end
            acn_pkg::OP_R0:    begin mul_a = {9'b0, r_g[23:0]}; mul_b = {1'b0, r_lr}; end
            acn_pkg::OP_R1:    begin mul_a = {17'b0, r_g[39:24]}; mul_b = {1'b0, r_lr}; end
            default:           begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign prod      = 50'(mul_a) * 50'(mul_b);
    assign prod_ext  = {16'b0, prod};
    assign acc_rnd16 = r_acc + 66'd32768;
    assign acc_rnd24 = r_acc + 66'h800000;

    // Mean update
    assign step   = acc_rnd16[48:16];
    assign mn34   = d0[32] ? (34'(r_m) - 34'(step)) : (34'(r_m) + 34'(step));
    assign mn_sat = (mn34 > 34'sh07FFFFFFF) ? 32'sh7FFFFFFF :
                    (mn34 < -34'sh080000000) ? 32'sh80000000 : 32'(mn34);

    // Rate update with clamp
    assign nr_sum = 34'(r_lr) + acc_rnd24[57:24];
    always_comb begin
        if (r_lr == 16'd0) nr_raw = '0;
        else if (|r_g[48:40]) nr_raw = 34'(acn_pkg::RATE_MAX);
        else nr_raw = nr_sum;
        if (nr_raw > 34'(acn_pkg::RATE_MAX)) nr = acn_pkg::RATE_MAX;
        else if (nr_raw < 34'(acn_pkg::RATE_MIN)) nr = acn_pkg::RATE_MIN;
        else nr = nr_raw[15:0];
    end

    // Square root step and divide step
    assign sq_t = r_sr + r_sb;
    assign dv_t = {r_rem, r_dn[48]};
    assign dv_s = {1'b0, r_s};

    // Quotient saturation
    assign qc = (r_dn > 49'h100000000) ? 33'h100000000 : r_dn[32:0];
    always_comb begin
        if (!r_neg) quot = (qc > 33'h07FFFFFFF) ? 32'sh7FFFFFFF : 32'(qc);
        else quot = (qc >= 33'h080000000) ? 32'sh80000000 : 32'(-qc);
    end

    assign out_free = !r_ovalid || !i_stall;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= acn_pkg::ACTIVE_RESET;
            r_irate  <= acn_pkg::RATE_RESET;
            r_gain   <= acn_pkg::GAIN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                acn_pkg::CFG_ACTIVE: r_active <= i_cfg_wdata[4:0];
                acn_pkg::CFG_RATE:   r_irate  <= i_cfg_wdata;
                acn_pkg::CFG_GAIN:   r_gain   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Channel state: reset, fit write-back, clears
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_mean_st[c] <= '0;
                r_var_st[c]  <= acn_pkg::VAR_ONE;
                r_rate_st[c] <= acn_pkg::RATE_RESET;
                r_seen_st[c] <= 1'b0;
            end
        end else begin
            case (i_cmd.op)
                acn_pkg::OP_RATE: begin
                    r_mean_st[ch_idx] <= r_m;
                    r_var_st[ch_idx]  <= r_vn;
                    r_rate_st[ch_idx] <= nr;
                    r_seen_st[ch_idx] <= 1'b1;
                end
                acn_pkg::OP_CLEAR: begin
                    r_mean_st[ch_idx] <= '0;
                    r_var_st[ch_idx]  <= acn_pkg::VAR_ONE;
                    r_rate_st[ch_idx] <= r_irate;
                    r_seen_st[ch_idx] <= 1'b0;
                end
                acn_pkg::OP_SWEEP: begin
                    r_mean_st[sw_idx] <= '0;
                    r_var_st[sw_idx]  <= acn_pkg::VAR_ONE;
                    r_rate_st[sw_idx] <= r_irate;
                    r_seen_st[sw_idx] <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // Working registers, advanced one command at a time
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            acn_pkg::OP_LOAD: begin
                r_kind <= i_data.kind;
                r_ch   <= i_data.channel;
                r_x    <= i_data.sample;
                r_ok   <= in_acc;
                r_m    <= r_mean_st[in_idx];
                r_v    <= r_var_st[in_idx];
                r_lr   <= r_rate_st[in_idx];
                r_seen <= r_seen_st[in_idx];
                r_sw   <= '0;
            end
            acn_pkg::OP_STEP, acn_pkg::OP_SQ_LO, acn_pkg::OP_V0, acn_pkg::OP_R0: begin
                r_acc <= prod_ext;
            end
            acn_pkg::OP_SQ_HI, acn_pkg::OP_V2: r_acc <= r_acc + (prod_ext << 16);
            acn_pkg::OP_V1:   r_acc <= r_acc + prod_ext;
            acn_pkg::OP_R1:   r_acc <= r_acc + (prod_ext << 24);
            acn_pkg::OP_MEAN: r_m  <= mn_sat;
            acn_pkg::OP_DIFF: r_ad <= mag0;
            acn_pkg::OP_D2:   r_d2 <= acc_rnd16[64:16];
            acn_pkg::OP_VSAT: r_vn <= (|acc_rnd16[65:48]) ? 32'hFFFFFFFF : acc_rnd16[47:16];
            acn_pkg::OP_G:    r_g  <= prod[48:0];
            acn_pkg::OP_RATE: begin
                r_v    <= r_vn;
                r_lr   <= nr;
                r_seen <= 1'b1;
            end
            acn_pkg::OP_SQ_INIT: begin
                r_sx  <= {1'b0, r_v, 16'b0};
                r_sr  <= '0;
                r_sb  <= 49'h1000000000000;
                r_cnt <= acn_pkg::SQRT_LAST;
            end
            acn_pkg::OP_SQRT: begin
                if (r_sx >= sq_t) begin
                    r_sx <= r_sx - sq_t;
                    r_sr <= (r_sr >> 1) + r_sb;
                end else begin
                    r_sr <= r_sr >> 1;
                end
                r_sb  <= r_sb >> 2;
                r_cnt <= r_cnt - 6'd1;
            end
            acn_pkg::OP_DIV_INIT: begin
                r_s   <= r_sr[24:0];
                r_dn  <= {mag0, 16'b0} + {25'b0, r_sr[24:1]};
                r_rem <= '0;
                r_neg <= d0[32];
                r_cnt <= acn_pkg::DIV_LAST;
            end
            acn_pkg::OP_DIV: begin
                if (dv_t >= dv_s) begin
                    r_rem <= 25'(dv_t - dv_s);
                    r_dn  <= {r_dn[47:0], 1'b1};
                end else begin
                    r_rem <= dv_t[24:0];
                    r_dn  <= {r_dn[47:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
            end
            acn_pkg::OP_SWEEP: r_sw <= r_sw + 9'd1;
            default: ;
        endcase
    end

    // Output register: load on emit, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.op == acn_pkg::OP_EMIT) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == acn_pkg::OP_EMIT) begin
            r_out.accepted    <= r_ok;
            r_out.forced_zero <= (i_cmd.res == acn_pkg::RES_FORCED);
            case (i_cmd.res)
                acn_pkg::RES_ECHO: r_out.normalized <= r_x;
                acn_pkg::RES_QUOT: r_out.normalized <= quot;
                default:           r_out.normalized <= '0;
            endcase
        end
    end

    // Status to the controller
    assign o_status.kind       = r_kind;
    assign o_status.ok         = r_ok;
    assign o_status.forced     = !r_seen || (r_v < acn_pkg::VAR_MIN);
    assign o_status.cnt_last   = (r_cnt == 6'd0);
    assign o_status.sweep_done = (r_sw >= lim9);
    assign o_status.out_free   = out_free;

    assign o_valid = r_ovalid;
    assign o_data  = r_out;

endmodule

FILE: hdl/adaptive_channel_normalizer_core.sv
// Per-channel adaptive z-score normalizer.
// Input channel: i_valid / o_stall with word i_data {kind, channel, sample}.
// A word is taken when i_valid is high and o_stall is low; o_stall stays
// high while an item is being worked on.
// Output channel: o_valid / i_stall with word o_data {normalized, accepted,
// forced_zero}; exactly one result word per input word.
// Configuration: i_cfg_we writes i_cfg_wdata to register i_cfg_idx (0 active
// channels, 1 initial rate, 2 adaptation gain); write only while idle, the block itself does not enforce it.
// A clear all sweeps every active channel; a fit uses the shared multiplier;
// a normalize not forced to zero runs 25 square root steps and 49 divide
// steps, one bit a cycle, and fit then normalize runs both.
// One item is worked on at a time; the multiplier is 33x17 and the root and
// divide loops are bit-serial.
// A finished word waits in the output register while the next word is taken;
// if the receiver stalls, the result holds and the next one waits to emit.
// Reset (synchronous, active low) restores configuration and control to defaults and
// every channel to mean 0, variance 1.0, rate 655 and not seen, at once.
module adaptive_channel_normalizer_core #(
    parameter int CHANNELS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  acn_pkg::t_in_word  i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output acn_pkg::t_out_word o_data,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_wdata
);

    acn_pkg::t_cmd    cmd;
    acn_pkg::t_status status;
    logic             busy;

    acn_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    acn_datapath #(
        .CHANNELS (CHANNELS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_data      (i_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_stall     (i_stall),
        .o_status    (status),
        .o_valid     (o_valid),
        .o_data      (o_data)
    );

    assign o_stall = busy;

endmodule
